>>> hdl/kabf_pkg.sv
// ---------------------------------------------------------------------------
// kabf_pkg: shared types and constants of the angle/bias Kalman filter
// Register indexes, fixed-point constants, the unit control struct and sat34.
// ---------------------------------------------------------------------------
package kabf_pkg;

   localparam int RegWidth  = 29;
   localparam int DataWidth = 32;
   localparam int QBits     = 28;

   typedef enum logic [1:0] {
      REG_TIME_STEP     = 2'd0,
      REG_ANGLE_NOISE   = 2'd1,
      REG_BIAS_NOISE    = 2'd2,
      REG_MEASURE_NOISE = 2'd3
   } reg_index_type;

   localparam logic [31:0] OneQ28     = 32'h1000_0000;
   localparam logic [31:0] SatMax     = 32'h7FFF_FFFF;
   localparam logic [31:0] SatMin     = 32'h8000_0000;
   localparam logic [28:0] TimeStepRst = 29'd1342177;
   localparam logic [28:0] AngleNzRst  = 29'd268435;
   localparam logic [28:0] BiasNzRst   = 29'd805306;
   localparam logic [28:0] MeasNzRst   = 29'd8053064;

   // Start/busy flags between the sequencer and a serial unit.
   typedef struct packed {
      logic start;
      logic busy;
   } unit_ctrl_type;

   // Saturate a 34-bit exact sum to signed 32 bits.
   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = SatMax;
      else if (v < -34'sh0_8000_0000) r = SatMin;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> hdl/kabf_if.sv
// ---------------------------------------------------------------------------
// kabf_stream_if: valid/ready channel carrying two 32-bit words
// One beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface kabf_stream_if;
   logic        valid;
   logic        ready;
   logic [31:0] word0;
   logic [31:0] word1;
   modport source (output valid, output word0, output word1, input ready);
   modport sink   (input valid, input word0, input word1, output ready);
endinterface

>>> hdl/kabf_mul.sv
// ---------------------------------------------------------------------------
// kabf_mul: bit-serial signed multiplier with Q28 round and saturation
// Shift-and-add over the 32 multiplier bits, then round to nearest and clamp to 32 bits.
// ---------------------------------------------------------------------------
module kabf_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic        done,
   output logic [31:0] result
);
   import kabf_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] result_ff, result_in;
   logic [63:0] rounded;
   logic signed [63:0] shifted;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      rounded   = acc_ff + 64'h0000_0000_0800_0000;
      shifted   = $signed(rounded) >>> QBits;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {{32{op_a[31]}}, op_a};
         mplier_in = op_b;
         count_in  = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (count_ff == 6'd32) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (shifted > 64'sh7FFF_FFFF) result_in = SatMax;
            else if (shifted < -64'sh8000_0000) result_in = SatMin;
            else result_in = shifted[31:0];
         end else begin
            // The top multiplier bit carries negative weight.
            if (mplier_ff[0]) begin
               if (count_ff == 6'd31) acc_in = acc_ff - mcand_ff;
               else acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[31:1]};
            count_in  = count_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("multiplier done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff <= 6'd32) else $error("count overrun");
endmodule

>>> hdl/kabf_div.sv
// ---------------------------------------------------------------------------
// kabf_div: restoring divider, (num * 2^28) / den, truncated and saturated
// One quotient bit per cycle over the 60 dividend bits on magnitudes, sign applied last.
// ---------------------------------------------------------------------------
module kabf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] result
);
   import kabf_pkg::*;

   logic [59:0] dividend_ff, dividend_in;
   logic [32:0] rem_ff, rem_in;
   logic [59:0] quot_ff, quot_in;
   logic [31:0] dmag_ff, dmag_in;
   logic        neg_ff, neg_in;
   logic        zden_ff, zden_in;
   logic        nsign_ff, nsign_in;
   logic        nzero_ff, nzero_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] result_ff, result_in;
   logic [33:0] trial;
   logic [31:0] nmag;

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      dmag_in     = dmag_ff;
      neg_in      = neg_ff;
      zden_in     = zden_ff;
      nsign_in    = nsign_ff;
      nzero_in    = nzero_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      result_in   = result_ff;
      nmag        = num[31] ? (~num + 32'd1) : num;
      trial       = {rem_ff, dividend_ff[59]} - {2'b00, dmag_ff};
      if (start) begin
         dividend_in = {nmag, 28'd0};
         rem_in      = '0;
         quot_in     = '0;
         dmag_in     = den[31] ? (~den + 32'd1) : den;
         neg_in      = num[31] ^ den[31];
         zden_in     = (den == '0);
         nsign_in    = num[31];
         nzero_in    = (num == '0);
         count_in    = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (count_ff == 6'd60) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (zden_ff) begin
               if (nzero_ff) result_in = '0;
               else if (nsign_ff) result_in = SatMin;
               else result_in = SatMax;
            end else if (neg_ff) begin
               if (quot_ff > 60'h0_0000_0000_8000_0000) result_in = SatMin;
               else result_in = ~quot_ff[31:0] + 32'd1;
            end else begin
               if (quot_ff > 60'h0_0000_0000_7FFF_FFFF) result_in = SatMax;
               else result_in = quot_ff[31:0];
            end
         end else begin
            if (!trial[33]) begin
               rem_in  = trial[32:0];
               quot_in = {quot_ff[58:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[31:0], dividend_ff[59]};
               quot_in = {quot_ff[58:0], 1'b0};
            end
            dividend_in = {dividend_ff[58:0], 1'b0};
            count_in    = count_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      dmag_ff     <= dmag_in;
      neg_ff      <= neg_in;
      zden_ff     <= zden_in;
      nsign_ff    <= nsign_in;
      nzero_ff    <= nzero_in;
      count_ff    <= count_in;
      result_ff   <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !zden_ff && count_ff != 6'd0) |-> rem_ff < {1'b0, dmag_ff})
      else $error("remainder out of range");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
endmodule

>>> hdl/kalman_angle_bias_filter_core.sv
// ---------------------------------------------------------------------------
// kalman_angle_bias_filter_core: one-axis angle and gyro bias Kalman filter
// Sequencer around one serial multiplier and one serial divider.
// ---------------------------------------------------------------------------
// Usage: a beat on req carries measured_angle (word0) and turn_rate (word1),
// both signed Q4.28. For each beat one beat leaves on rsp with
// filtered_angle (word0) and rate_bias (word1). req_ready is high only while
// the sequencer is idle, so one sample is processed at a time.
// Sequence: 10 multiplications and 2 divisions run one after another on the
// shared units, between the register steps RATE, ANG1, INNER, COV2 and OUT.
// The multiplier (one bit a cycle) and divider (one quotient bit a cycle) set
// the pace; a new sample is accepted only once the sequencer is back in idle.
// Reset is synchronous: the estimates return to zero, the diagonal
// covariances to 1.0 and the registers to their defaults.
// When the receiver stalls the result waits in the output register while the
// next sample is accepted and processed; that result then waits in the
// sequencer until the register is free, and req_ready stays low meanwhile.
// csr registers may be written only while the block is idle.
// ---------------------------------------------------------------------------
module kalman_angle_bias_filter_core (
   input  logic                clock,
   input  logic                reset,
   kabf_stream_if.sink         req,
   kabf_stream_if.source       rsp,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [28:0]         csr_data
);
   import kabf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RATE, S_M_DTRATE, S_ANG1, S_M_DTP11, S_INNER, S_M_DTINNER,
      S_COV1, S_M_QB, S_COV2, S_D_K0, S_D_K1, S_Y,
      S_M_K0Y, S_M_K1Y, S_M_K0A, S_M_K0B, S_M_K1A, S_M_K1B, S_OUT
   } state_type;

   state_type   state_ff;
   logic        launched_ff;
   logic [28:0] dt_ff, qa_ff, qb_ff, rn_ff;
   logic [31:0] ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic [31:0] meas_ff, gyro_ff, t0_ff, t1_ff, k0_ff, k1_ff, y_ff;
   logic [31:0] a_ff, b_ff;
   logic        out_valid_ff;
   logic [31:0] out_ang_ff, out_bias_ff;
   logic        out_load;

   unit_ctrl_type mul_ctrl, div_ctrl;
   logic [31:0] mul_a, mul_b, div_n, div_d;
   logic        mul_done, div_done;
   logic [31:0] mul_res, div_res;

   kabf_mul u_mul (.clock, .reset, .start(mul_ctrl.start), .op_a(mul_a),
      .op_b(mul_b), .done(mul_done), .result(mul_res));
   kabf_div u_div (.clock, .reset, .start(div_ctrl.start), .num(div_n),
      .den(div_d), .done(div_done), .result(div_res));

   function automatic logic [33:0] sx(input logic [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic logic [33:0] zx(input logic [28:0] v);
      return {5'd0, v};
   endfunction

   logic is_mul, is_div;
   assign is_mul = (state_ff == S_M_DTRATE) || (state_ff == S_M_DTP11) ||
      (state_ff == S_M_DTINNER) || (state_ff == S_M_QB) ||
      (state_ff == S_M_K0Y) || (state_ff == S_M_K1Y) || (state_ff == S_M_K0A) ||
      (state_ff == S_M_K0B) || (state_ff == S_M_K1A) || (state_ff == S_M_K1B);
   assign is_div = (state_ff == S_D_K0) || (state_ff == S_D_K1);

   assign mul_ctrl.start = is_mul && !launched_ff;
   assign mul_ctrl.busy  = is_mul && launched_ff;
   assign div_ctrl.start = is_div && !launched_ff;
   assign div_ctrl.busy  = is_div && launched_ff;

   always_comb begin
      mul_a = {3'd0, dt_ff};
      mul_b = t0_ff;
      unique case (state_ff)
         S_M_DTP11:   mul_b = p11_ff;
         S_M_DTINNER: mul_b = t1_ff;
         S_M_QB:      mul_b = {3'd0, qb_ff};
         S_M_K0Y:     begin mul_a = k0_ff; mul_b = y_ff; end
         S_M_K1Y:     begin mul_a = k1_ff; mul_b = y_ff; end
         S_M_K0A:     begin mul_a = k0_ff; mul_b = a_ff; end
         S_M_K0B:     begin mul_a = k0_ff; mul_b = b_ff; end
         S_M_K1A:     begin mul_a = k1_ff; mul_b = a_ff; end
         S_M_K1B:     begin mul_a = k1_ff; mul_b = b_ff; end
         default:     mul_b = t0_ff;
      endcase
      div_n = (state_ff == S_D_K1) ? p10_ff : p00_ff;
      div_d = t1_ff;
   end

   assign req.ready = (state_ff == S_IDLE);

   // The finished result moves out when the output register is empty or
   // its beat leaves in the same cycle.
   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         dt_ff <= TimeStepRst; qa_ff <= AngleNzRst;
         qb_ff <= BiasNzRst;   rn_ff <= MeasNzRst;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= OneQ28; p01_ff <= '0; p10_ff <= '0; p11_ff <= OneQ28;
      end else begin
         if (csr_write) begin
            unique case (reg_index_type'(csr_index))
               REG_TIME_STEP:     dt_ff <= csr_data;
               REG_ANGLE_NOISE:   qa_ff <= csr_data;
               REG_BIAS_NOISE:    qb_ff <= csr_data;
               REG_MEASURE_NOISE: rn_ff <= csr_data;
            endcase
         end
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         if (is_mul || is_div) launched_ff <= !(mul_done || div_done);
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               meas_ff  <= req.word0;
               gyro_ff  <= req.word1;
               state_ff <= S_RATE;
            end
            S_RATE: begin
               t0_ff    <= sat34(sx(gyro_ff) - sx(bias_ff));
               state_ff <= S_M_DTRATE;
            end
            S_M_DTRATE: if (mul_done) begin
               t0_ff <= mul_res; state_ff <= S_ANG1;
            end
            S_ANG1: begin
               ang_ff   <= sat34(sx(ang_ff) + sx(t0_ff));
               state_ff <= S_M_DTP11;
            end
            S_M_DTP11: if (mul_done) begin
               t0_ff <= mul_res; state_ff <= S_INNER;
            end
            S_INNER: begin
               t1_ff <= sat34(sx(t0_ff) - sx(p01_ff) - sx(p10_ff) + zx(qa_ff));
               p01_ff <= sat34(sx(p01_ff) - sx(t0_ff));
               p10_ff <= sat34(sx(p10_ff) - sx(t0_ff));
               state_ff <= S_M_DTINNER;
            end
            S_M_DTINNER: if (mul_done) begin
               p00_ff <= sat34(sx(p00_ff) + sx(mul_res)); state_ff <= S_M_QB;
            end
            S_M_QB: if (mul_done) begin
               p11_ff <= sat34(sx(p11_ff) + sx(mul_res)); state_ff <= S_COV2;
            end
            S_COV2: begin
               t1_ff    <= sat34(sx(p00_ff) + zx(rn_ff));
               a_ff     <= p00_ff;
               b_ff     <= p01_ff;
               y_ff     <= sat34(sx(meas_ff) - sx(ang_ff));
               state_ff <= S_D_K0;
            end
            S_D_K0: if (div_done) begin
               k0_ff <= div_res; state_ff <= S_D_K1;
            end
            S_D_K1: if (div_done) begin
               k1_ff <= div_res; state_ff <= S_M_K0Y;
            end
            S_M_K0Y: if (mul_done) begin
               ang_ff <= sat34(sx(ang_ff) + sx(mul_res)); state_ff <= S_M_K1Y;
            end
            S_M_K1Y: if (mul_done) begin
               bias_ff <= sat34(sx(bias_ff) + sx(mul_res)); state_ff <= S_M_K0A;
            end
            S_M_K0A: if (mul_done) begin
               p00_ff <= sat34(sx(a_ff) - sx(mul_res)); state_ff <= S_M_K0B;
            end
            S_M_K0B: if (mul_done) begin
               p01_ff <= sat34(sx(b_ff) - sx(mul_res)); state_ff <= S_M_K1A;
            end
            S_M_K1A: if (mul_done) begin
               p10_ff <= sat34(sx(p10_ff) - sx(mul_res)); state_ff <= S_M_K1B;
            end
            S_M_K1B: if (mul_done) begin
               p11_ff <= sat34(sx(p11_ff) - sx(mul_res)); state_ff <= S_OUT;
            end
            S_OUT: if (out_load) begin
               out_ang_ff   <= ang_ff;
               out_bias_ff  <= bias_ff;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.word0 = out_ang_ff;
   assign rsp.word1 = out_bias_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_ctrl.start && div_ctrl.start)) else $error("two units started");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("accept while busy");
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result without sequence");
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> is_mul) else $error("stray multiplier result");
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stream test of the angle/bias Kalman filter core
// A queue of samples feeds a driver; each accepted sample runs through a
// fixed-point estimator kept here, and every result beat is checked against
// the oldest predicted estimate. Filter settings change between idle phases.
// ---------------------------------------------------------------------------
module tb_top;
   import kabf_pkg::*;

   typedef struct packed {
      logic signed [31:0] meas;
      logic signed [31:0] rate;
   } sample_t;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] bias;
   } estimate_t;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [28:0] csr_data;

   kabf_stream_if req ();
   kabf_stream_if rsp ();

   kalman_angle_bias_filter_core uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Estimator state and filter settings.
   longint dt_q, q_angle, q_bias, r_meas;
   longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

   sample_t   pending_samples[$];
   estimate_t expected_estimates[$];
   int        mismatches = 0;
   int        samples_taken = 0;
   bit        gaps_enabled = 1'b0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q4.28 product, rounded to nearest with ties upward.
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b + (64'sd1 <<< (QBits - 1));
      return sat32(p >>> QBits);
   endfunction

   function automatic longint qdiv(longint num, longint den);
      if (den == 0) begin
         if (num > 0) return 64'sd2147483647;
         if (num < 0) return -64'sd2147483648;
         return 0;
      end
      return sat32((num * (64'sd1 <<< QBits)) / den);
   endfunction

   function automatic estimate_t filter_sample(sample_t s);
      longint rate, dtp11, inner, innov_var, k0, k1, innov, a, b;
      estimate_t e;
      rate = sat32(longint'(s.rate) - est_bias);
      est_angle = sat32(est_angle + qmul(dt_q, rate));
      dtp11 = qmul(dt_q, p_bb);
      inner = sat32(dtp11 - p_ab - p_ba + q_angle);
      p_aa = sat32(p_aa + qmul(dt_q, inner));
      p_ab = sat32(p_ab - dtp11);
      p_ba = sat32(p_ba - dtp11);
      p_bb = sat32(p_bb + qmul(q_bias, dt_q));
      innov_var = sat32(p_aa + r_meas);
      k0 = qdiv(p_aa, innov_var);
      k1 = qdiv(p_ba, innov_var);
      innov = sat32(longint'(s.meas) - est_angle);
      est_angle = sat32(est_angle + qmul(k0, innov));
      est_bias = sat32(est_bias + qmul(k1, innov));
      a = p_aa;
      b = p_ab;
      p_aa = sat32(a - qmul(k0, a));
      p_ab = sat32(b - qmul(k0, b));
      p_ba = sat32(p_ba - qmul(k1, a));
      p_bb = sat32(p_bb - qmul(k1, b));
      e.angle = est_angle[31:0];
      e.bias = est_bias[31:0];
      return e;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 5);
      return $urandom_range(20, 90);
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      mismatches++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Driver: one beat per accepted sample, predicted as it is taken.
   int send_gap;
   always @(posedge clock) begin
      sample_t s;
      logic fire;
      if (reset) begin
         req.valid <= 1'b0;
         send_gap = 0;
      end else begin
         fire = req.valid && req.ready;
         if (fire) begin
            s.meas = req.word0;
            s.rate = req.word1;
            expected_estimates.push_back(filter_sample(s));
            samples_taken++;
            send_gap = pick_gap();
         end
         if (!req.valid || fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               s = pending_samples.pop_front();
               req.word0 <= s.meas;
               req.word1 <= s.rate;
               req.valid <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off while the sender keeps offering samples.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && samples_taken == 300) begin
         hold_left <= 3000;
         hold_done <= 1'b1;
      end
   end

   // Monitor: checks each result beat and idles the ready line at random.
   int recv_gap;
   always @(posedge clock) begin
      estimate_t want;
      if (reset) begin
         rsp.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_estimates.size() == 0) begin
               $display("result beat with no sample outstanding");
               mismatches++;
            end else begin
               want = expected_estimates.pop_front();
               if (rsp.word0 !== want.angle) flag_mismatch("filtered_angle", rsp.word0, want.angle);
               if (rsp.word1 !== want.bias) flag_mismatch("rate_bias", rsp.word1, want.bias);
            end
            recv_gap = pick_gap();
         end
         if (hold_left != 0) begin
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req.valid || expected_estimates.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [28:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         REG_TIME_STEP:     dt_q = value;
         REG_ANGLE_NOISE:   q_angle = value;
         REG_BIAS_NOISE:    q_bias = value;
         REG_MEASURE_NOISE: r_meas = value;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_filter(logic [28:0] dt, logic [28:0] qa, logic [28:0] qb,
                             logic [28:0] rm);
      write_reg(REG_TIME_STEP, dt);
      write_reg(REG_ANGLE_NOISE, qa);
      write_reg(REG_BIAS_NOISE, qb);
      write_reg(REG_MEASURE_NOISE, rm);
   endtask

   task automatic add_sample(logic [31:0] m, logic [31:0] r);
      sample_t s;
      s.meas = m;
      s.rate = r;
      pending_samples.push_back(s);
   endtask

   // Mostly a plausible tilt trace with gyro noise, some full-range junk.
   task automatic add_random_run(int count);
      int tilt;
      int drift;
      tilt = $urandom_range(0, 120 * 65536) - 60 * 65536;
      drift = $urandom_range(0, 10 * 65536) - 5 * 65536;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            add_sample($urandom, $urandom);
         end else begin
            tilt += $urandom_range(0, 2 * 65536) - 65536;
            add_sample(tilt + $urandom_range(0, 4 * 65536) - 2 * 65536,
                       drift + $urandom_range(0, 400 * 65536) - 200 * 65536);
         end
      end
   endtask

   initial begin
      logic [31:0] edges[6];
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = REG_TIME_STEP;
      csr_data = '0;
      req.valid = 1'b0;
      req.word0 = '0;
      req.word1 = '0;
      rsp.ready = 1'b0;
      dt_q = TimeStepRst;
      q_angle = AngleNzRst;
      q_bias = BiasNzRst;
      r_meas = MeasNzRst;
      est_angle = 0;
      est_bias = 0;
      p_aa = OneQ28;
      p_ab = 0;
      p_ba = 0;
      p_bb = OneQ28;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: default settings and extreme angles and rates.
      edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
      foreach (edges[i]) add_sample(edges[i], 32'h0);
      foreach (edges[i]) add_sample(32'h0, edges[i]);
      add_sample(32'h7FFF_FFFF, 32'h8000_0000);
      add_sample(32'h8000_0000, 32'h7FFF_FFFF);
      add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_sample(32'h8000_0000, 32'h8000_0000);
      wait_idle();

      // All four settings at 1.0, the largest that this bench writes.
      set_filter(29'h1000_0000, 29'h1000_0000, 29'h1000_0000, 29'h1000_0000);
      gaps_enabled = 1'b1;
      add_random_run(150);
      wait_idle();

      // No time step, no process noise and the smallest measurement noise.
      set_filter(29'd0, 29'd0, 29'd0, 29'd1);
      gaps_enabled = 1'b0;
      add_random_run(150);
      wait_idle();

      repeat (5) begin
         set_filter($urandom_range(0, 32'h1000_0000), $urandom_range(0, 32'h1000_0000),
                    $urandom_range(0, 32'h1000_0000), $urandom_range(1, 32'h1000_0000));
         gaps_enabled = $urandom_range(0, 3) != 0;
         add_random_run(200);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
